/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/ptcc_pkg.sv */
// Types and constants of the press-triggered capture controller.
// No dependencies.
package ptcc_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int TICK_BITS    = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int PRESS_RUN_DEFAULT = 5;

    localparam logic [TICK_BITS-1:0] LIMIT_RESET = 8'd19;
    localparam logic [TICK_BITS-1:0] TICK_MAX    = 8'hFF;

    // opcodes
    localparam logic [1:0] OP_TICK         = 2'd0;
    localparam logic [1:0] OP_HOLD_EXPIRED = 2'd1;
    localparam logic [1:0] OP_PROC_DONE    = 2'd2;

    // modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PROC = 2'd2;
    localparam logic [1:0] MODE_ACC  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BUTTON_LEVEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_TOL    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_LIMIT   = 2'd2;

    typedef struct packed {
        logic [1:0]             opcode;
        logic [SAMPLE_BITS-1:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [1:0] mode;
        logic       capture_enable;
        logic       recording_done;
        logic       start_hold_timer;
        logic       access_line;
        logic       blue_lamp;
        logic       yellow_lamp;
    } t_out_item;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] button_level;
        logic [SAMPLE_BITS-1:0] level_tolerance;
        logic [TICK_BITS-1:0]   record_tick_limit;
    } t_cfg;

endpackage

/* rtl/ptcc_core.sv */
// Mode state and per-item update of the capture controller.
// Depends on ptcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptcc_core
    import ptcc_pkg::*;
#(
    parameter int PRESS_RUN = PRESS_RUN_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [1:0]           r_mode, n_mode;
    logic [PRESS_RUN-1:0] r_history, n_history;
    logic [TICK_BITS-1:0] r_ticks, n_ticks;
    logic                 r_access, n_access;
    logic                 done_pulse, hold_pulse, pressed;
    logic [SAMPLE_BITS:0] lo_side, hi_side, samp_ext;

    // open window test, widened by one bit so neither bound wraps:
    // s > c - t  <=>  s + t > c ;  s < c + t
    assign samp_ext = {1'b0, i_item.adc_sample};
    assign lo_side  = samp_ext + {1'b0, i_cfg.level_tolerance};
    assign hi_side  = {1'b0, i_cfg.button_level} + {1'b0, i_cfg.level_tolerance};
    assign pressed  = (lo_side > {1'b0, i_cfg.button_level}) && (samp_ext < hi_side);

    always_comb begin
        n_mode     = r_mode;
        n_history  = r_history;
        n_ticks    = r_ticks;
        n_access   = r_access;
        done_pulse = 1'b0;
        hold_pulse = 1'b0;
        case (i_item.opcode)
            OP_TICK: begin
                if (r_mode == MODE_IDLE) begin
                    n_history = {r_history[PRESS_RUN-2:0], pressed};
                    if (&n_history) begin
                        n_mode = MODE_REC;
                    end
                end else if (r_mode == MODE_REC) begin
                    if (!pressed || (r_ticks >= i_cfg.record_tick_limit)) begin
                        n_mode     = MODE_PROC;
                        n_ticks    = '0;
                        n_history  = '0;
                        done_pulse = 1'b1;
                    end else if (r_ticks != TICK_MAX) begin
                        n_ticks = r_ticks + 1'b1;
                    end
                end
            end
            OP_HOLD_EXPIRED: begin
                n_mode   = MODE_IDLE;
                n_access = 1'b0;
            end
            OP_PROC_DONE: begin
                if (r_mode == MODE_PROC) begin
                    n_mode     = MODE_ACC;
                    n_access   = 1'b1;
                    hold_pulse = 1'b1;
                end
            end
            default: begin
                // unused opcode: hold everything
            end
        endcase
    end

    always_comb begin
        o_result.mode             = n_mode;
        o_result.capture_enable   = (n_mode == MODE_REC);
        o_result.recording_done   = done_pulse;
        o_result.start_hold_timer = hold_pulse;
        o_result.access_line      = n_access;
        o_result.blue_lamp        = (n_mode == MODE_IDLE);
        o_result.yellow_lamp      = (n_mode == MODE_REC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_history <= '0;
            r_ticks   <= '0;
            r_access  <= 1'b0;
        end else if (i_advance) begin
            r_mode    <= n_mode;
            r_history <= n_history;
            r_ticks   <= n_ticks;
            r_access  <= n_access;
        end
    end

    // access is set only on entering access granted and dropped on leaving it
    `ASSERT_ALWAYS(a_access_tracks_mode, i_clk, i_rst_n, r_access == (r_mode == MODE_ACC))
    `ASSERT_NEXT(a_done_enters_proc, i_clk, i_rst_n, i_advance && done_pulse, r_mode == MODE_PROC && r_ticks == '0)
    `ASSERT_NEXT(a_hold_enters_acc, i_clk, i_rst_n, i_advance && hold_pulse, r_mode == MODE_ACC && r_access)
    `ASSERT_IMPLIES(a_ticks_idle_hist, i_clk, i_rst_n, r_mode == MODE_PROC, r_history == '0)

endmodule

/* rtl/press_triggered_capture_control_unit.sv */
// An accepted item goes to the input register, then to the result register, which
// shows its result. Throughput: one item per cycle while the output is not stalled;
// the mode state is updated once per item in the single step between the two registers.
// Reset (synchronous, active low) empties both registers, returns to idle with clear
// history, tick count and access, and loads button level 0, tolerance 0, tick limit 19.
// Depends on ptcc_pkg, ptcc_core and assert_macros.svh.
`include "assert_macros.svh"

module press_triggered_capture_control_unit
    import ptcc_pkg::*;
#(
    parameter int PRESS_RUN = PRESS_RUN_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]  i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    t_out_item step_result;
    logic      advance;

    // move the staged item into the result register when that slot frees up
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_level      <= '0;
            r_cfg.level_tolerance   <= '0;
            r_cfg.record_tick_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BUTTON_LEVEL: r_cfg.button_level    <= i_cfg_data;
                CFG_LEVEL_TOL:    r_cfg.level_tolerance <= i_cfg_data;
                CFG_TICK_LIMIT:   r_cfg.record_tick_limit <= i_cfg_data[TICK_BITS-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    ptcc_core #(
        .PRESS_RUN (PRESS_RUN)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (r_cfg),
        .o_result  (step_result)
    );

    `ASSERT_NEXT(a_stall_keeps_result, i_clk, i_rst_n, r_out_valid && !i_out_ready,
                 r_out_valid && $stable(r_out_item))
    `ASSERT_NEXT(a_accept_fills_stage, i_clk, i_rst_n, i_in_valid && o_in_ready, r_in_valid)
    `ASSERT_IMPLIES(a_full_stall_blocks, i_clk, i_rst_n, r_in_valid && r_out_valid && !i_out_ready, !o_in_ready)

endmodule
